// File: hdl/rchk_pkg.sv
// ----------------------------------------------------------------------------
// rchk_pkg
// Shared constants and types for the rectangle-center Hilbert key pipeline.
// ----------------------------------------------------------------------------
package rchk_pkg;

  localparam int KEY_W         = 64;  // result key width
  localparam int TOP_W         = 5;   // width of the top-bit register
  localparam int FRAC_BITS_DEF = 20;  // default fraction bits of a coordinate
  localparam int STEP_BITS     = 8;   // curve steps resolved per walk stage

  localparam logic [TOP_W-1:0] TOP_RESET = 5'd31;

  // Pending complement state of the walk: flip_d0 applies to x bits where
  // (x xor y) is 0, flip_d1 to x bits where it is 1.
  typedef struct packed {
    logic flip_d0;
    logic flip_d1;
  } walk_flags_t;

endpackage

// File: hdl/rchk_walk_stage.sv
// ----------------------------------------------------------------------------
// rchk_walk_stage
// One registered slice of the Hilbert walk, bits HI down to LO.
// ----------------------------------------------------------------------------
module rchk_walk_stage #(
  parameter int COORD_BITS = 21,
  parameter int HI         = 20,
  parameter int LO         = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [COORD_BITS-1:0]       up_x,
  input  logic [COORD_BITS-1:0]       up_d,
  input  logic [rchk_pkg::TOP_W-1:0]  up_top,
  input  rchk_pkg::walk_flags_t       up_flags,
  input  logic [2*COORD_BITS-1:0]     up_key,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [COORD_BITS-1:0]       dn_x,
  output logic [COORD_BITS-1:0]       dn_d,
  output logic [rchk_pkg::TOP_W-1:0]  dn_top,
  output rchk_pkg::walk_flags_t       dn_flags,
  output logic [2*COORD_BITS-1:0]     dn_key
);
  import rchk_pkg::*;

  logic                    valid_r;
  logic [COORD_BITS-1:0]   x_r;
  logic [COORD_BITS-1:0]   d_r;
  logic [TOP_W-1:0]        top_r;
  walk_flags_t             flags_r;
  walk_flags_t             flags_nxt;
  logic [2*COORD_BITS-1:0] key_r;
  logic [2*COORD_BITS-1:0] key_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Resolve each bit from the top of the slice down; steps above top_bit
  // leave the flags alone and contribute zero key bits.
  always_comb begin
    logic db;
    logic xb;
    flags_nxt = up_flags;
    key_nxt   = up_key;
    for (int j = HI; j >= LO; j--) begin
      db = up_d[j];
      xb = up_x[j] ^ (db ? flags_nxt.flip_d1 : flags_nxt.flip_d0);
      if (TOP_W'(j) <= up_top) begin
        key_nxt[2*j +: 2] = {xb, db};
        if (db && xb) begin
          flags_nxt.flip_d0 = !flags_nxt.flip_d0;
        end
        if (!db && !xb) begin
          flags_nxt.flip_d1 = !flags_nxt.flip_d1;
        end
      end else begin
        key_nxt[2*j +: 2] = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r     <= up_x;
      d_r     <= up_d;
      top_r   <= up_top;
      flags_r <= flags_nxt;
      key_r   <= key_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_d     = d_r;
  assign dn_top   = top_r;
  assign dn_flags = flags_r;
  assign dn_key   = key_r;

endmodule

// File: hdl/rect_center_hilbert_key.sv
// ----------------------------------------------------------------------------
// rect_center_hilbert_key
// Hilbert curve key of a rectangle's center, one rectangle per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: low_x, low_y, high_x,
//          |     |                      |   high_y (COORD_BITS each)
//  out_    | out | out_tvalid/out_tready| out_tdata: curve_key (64 bits)
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data: top_bit (5 bits)
//
//  Throughput: one word per cycle while out_tready is high. Each word passes
//  the center stage and then the walk stages, which resolve eight curve steps
//  each.
//  Reset (rst_n low, synchronous) empties the pipeline and sets top_bit to 31.
//  Stalls: out_tready low holds the last stage; ready ripples back stage by
//  stage, so bubbles are squeezed out and no word is lost or repeated.
// ----------------------------------------------------------------------------
module rect_center_hilbert_key #(
  parameter  int FRAC_BITS = rchk_pkg::FRAC_BITS_DEF,
  localparam int CB        = FRAC_BITS + 1,
  localparam int IN_W      = ((4 * CB + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // low_x, low_y, high_x, high_y from bit 0 up, zero padded to bytes
  input  logic [IN_W-1:0]             in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // curve_key
  output logic [rchk_pkg::KEY_W-1:0]  out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [rchk_pkg::TOP_W-1:0]  cfg_wr_data
);
  import rchk_pkg::*;

  localparam int COORD_BITS = CB;
  localparam int KW         = 2 * COORD_BITS;
  localparam int NST        = (COORD_BITS + STEP_BITS - 1) / STEP_BITS;

  // Configuration register
  logic [TOP_W-1:0] top_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_bit_r <= TOP_RESET;
    end else if (cfg_wr_en) begin
      top_bit_r <= cfg_wr_data;
    end
  end

  // Unpack the rectangle
  logic [COORD_BITS-1:0] low_x;
  logic [COORD_BITS-1:0] low_y;
  logic [COORD_BITS-1:0] high_x;
  logic [COORD_BITS-1:0] high_y;

  assign low_x  = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign low_y  = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign high_x = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign high_y = in_tdata[3*COORD_BITS +: COORD_BITS];

  // Pipeline links: index k feeds walk stage k, index NST is the output.
  logic [NST:0]                 pv;
  logic [NST:0]                 pr;
  logic [NST:0][COORD_BITS-1:0] px;
  logic [NST:0][COORD_BITS-1:0] pd;
  logic [NST:0][TOP_W-1:0]      ptop;
  walk_flags_t [NST:0]          pflags;
  logic [NST:0][KW-1:0]         pkey;

  // Center stage: form the centers with one extra sum bit, take x xor y and
  // preload the flags for curve steps above the coordinate width. Those
  // steps see x = y = 0, append zero and each toggle flip_d1.
  logic                  s0_valid_r;
  logic [COORD_BITS-1:0] s0_x_r;
  logic [COORD_BITS-1:0] s0_d_r;
  logic [TOP_W-1:0]      s0_top_r;
  walk_flags_t           s0_flags_r;

  logic [COORD_BITS:0]   sum_x;
  logic [COORD_BITS:0]   sum_y;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [TOP_W-1:0]      extra_steps;
  walk_flags_t           s0_flags_nxt;

  assign sum_x       = {1'b0, low_x} + {1'b0, high_x};
  assign sum_y       = {1'b0, low_y} + {1'b0, high_y};
  assign cx          = sum_x[COORD_BITS:1];
  assign cy          = sum_y[COORD_BITS:1];
  assign extra_steps = top_bit_r - TOP_W'(COORD_BITS - 1);

  always_comb begin
    s0_flags_nxt.flip_d0 = 1'b0;
    s0_flags_nxt.flip_d1 = (top_bit_r > TOP_W'(COORD_BITS - 1)) && extra_steps[0];
  end

  assign in_tready = !s0_valid_r || pr[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_x_r     <= cx;
      s0_d_r     <= cx ^ cy;
      s0_top_r   <= top_bit_r;
      s0_flags_r <= s0_flags_nxt;
    end
  end

  assign pv[0]     = s0_valid_r;
  assign px[0]     = s0_x_r;
  assign pd[0]     = s0_d_r;
  assign ptop[0]   = s0_top_r;
  assign pflags[0] = s0_flags_r;
  assign pkey[0]   = '0;

  // Walk stages, highest coordinate bits first
  for (genvar k = 0; k < NST; k++) begin : g_walk
    localparam int HI = COORD_BITS - 1 - k * STEP_BITS;
    localparam int LO = (HI + 1 > STEP_BITS) ? HI + 1 - STEP_BITS : 0;

    rchk_walk_stage #(
      .COORD_BITS (COORD_BITS),
      .HI         (HI),
      .LO         (LO)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (pv[k]),
      .up_ready (pr[k]),
      .up_x     (px[k]),
      .up_d     (pd[k]),
      .up_top   (ptop[k]),
      .up_flags (pflags[k]),
      .up_key   (pkey[k]),
      .dn_valid (pv[k+1]),
      .dn_ready (pr[k+1]),
      .dn_x     (px[k+1]),
      .dn_d     (pd[k+1]),
      .dn_top   (ptop[k+1]),
      .dn_flags (pflags[k+1]),
      .dn_key   (pkey[k+1])
    );
  end

  // Output: last walk stage register drives the port directly
  assign pr[NST]    = out_tready;
  assign out_tvalid = pv[NST];
  assign out_tdata  = {{(KEY_W - KW){1'b0}}, pkey[NST]};

`ifndef SYNTHESIS
  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // An empty output register means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output drained");

  // A stalled center stage keeps its word
  a_center_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !pr[0] |=> s0_valid_r)
    else $error("center stage dropped a word");

  // Key bits above the walked range are zero
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> ((7'(ptop[NST]) << 1) + 7'd2)) == '0)
    else $error("key bits set above top_bit range");
`endif

endmodule

// File: tb/sv/rect_center_hilbert_key_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_center_hilbert_key_checker
// Watches the rectangle and key streams of the Hilbert key block, predicts
// the key of every accepted rectangle and compares it with the key that
// comes out, in order.
// ----------------------------------------------------------------------------
module rect_center_hilbert_key_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  // low_x, low_y, high_x, high_y from bit 0 up, zero padded to bytes
  input  logic [87:0]                        in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // curve_key
  input  logic [rchk_pkg::KEY_W-1:0]         out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [rchk_pkg::TOP_W-1:0]         cfg_wr_data,
  output int                                 mismatch_count,
  output int                                 keys_outstanding
);

  localparam int CB = rchk_pkg::FRAC_BITS_DEF + 1;

  logic [rchk_pkg::KEY_W-1:0] expected_keys[$];
  logic [rchk_pkg::TOP_W-1:0] top_bit_model;

  function automatic logic [31:0] center_of(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
    logic [CB:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return {{(32 - CB){1'b0}}, sum[CB:1]};
  endfunction

  function automatic logic [rchk_pkg::KEY_W-1:0] hilbert_key_of(
      input logic [31:0] cx, input logic [31:0] cy, input logic [rchk_pkg::TOP_W-1:0] top);
    logic [31:0] x;
    logic [31:0] d;
    logic [31:0] nd;
    logic [rchk_pkg::KEY_W-1:0] key;
    x   = cx;
    d   = cx ^ cy;
    nd  = ~d;
    key = '0;
    for (int b = 31; b >= 0; b--) begin
      if (b <= top) begin
        if (d[b]) begin
          if (!x[b]) begin
            key = {key[61:0], 2'd1};
          end else begin
            x   = x ^ nd;
            key = {key[61:0], 2'd3};
          end
        end else begin
          if (!x[b]) begin
            x   = x ^ d;
            key = {key[61:0], 2'd0};
          end else begin
            key = {key[61:0], 2'd2};
          end
        end
      end
    end
    return key;
  endfunction

  initial begin
    mismatch_count   = 0;
    keys_outstanding = 0;
    top_bit_model    = rchk_pkg::TOP_RESET;
  end

  always @(posedge clk) begin
    logic [rchk_pkg::KEY_W-1:0] want;
    logic [rchk_pkg::KEY_W-1:0] pred;
    if (!rst_n) begin
      top_bit_model = rchk_pkg::TOP_RESET;
      expected_keys.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        pred = hilbert_key_of(
            center_of(in_tdata[0*CB +: CB], in_tdata[2*CB +: CB]),
            center_of(in_tdata[1*CB +: CB], in_tdata[3*CB +: CB]),
            top_bit_model);
        expected_keys.insert(expected_keys.size(), pred);
      end
      if (out_tvalid && out_tready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key, expected none, actual %h", $time, out_tdata);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_keys.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: curve_key mismatch, expected %h, actual %h",
                     $time, want, out_tdata);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (cfg_wr_en)
        top_bit_model = cfg_wr_data;
    end
    keys_outstanding <= expected_keys.size();
  end

endmodule

// File: tb/sv/rect_center_hilbert_key_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_center_hilbert_key_test
// Drives rectangles into the Hilbert key block under random idling on both
// sides, across several top_bit settings, and lets the checker compare every
// key. Prints the verdict once all keys have drained.
// ----------------------------------------------------------------------------
module rect_center_hilbert_key_test;

  localparam int CB          = rchk_pkg::FRAC_BITS_DEF + 1;
  localparam int TW          = rchk_pkg::TOP_W;
  localparam int IN_W        = ((4 * CB + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CB-1:0] ONE  = CB'(1 << rchk_pkg::FRAC_BITS_DEF);
  localparam logic [CB-1:0] CMAX = '1;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  // low_x, low_y, high_x, high_y from bit 0 up, zero padded to bytes
  logic [IN_W-1:0]             in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  // curve_key
  logic [rchk_pkg::KEY_W-1:0]  out_tdata;
  logic                        cfg_wr_en;
  logic [rchk_pkg::TOP_W-1:0]  cfg_wr_data;

  int mismatch_count;
  int keys_outstanding;
  int cycle_count = 0;

  // Idling switches, flipped per phase so some stretches run back to back.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit rx_hold_req    = 1'b0;

  always #10 clk = ~clk;

  rect_center_hilbert_key dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rect_center_hilbert_key_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .keys_outstanding (keys_outstanding)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Key receiver: stall a random number of cycles before each word, and
  // hold off for a long stretch when asked, so the pipeline backs up.
  initial begin
    int stall;
    out_tready <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = receiver_idles ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [CB-1:0] draw_coord();
    case ($urandom_range(0, 4))
      0:       return CB'($urandom_range(0, ONE));
      1:       return CB'($urandom_range(0, ONE));
      2:       return CB'($urandom()) & CMAX;
      3:       return CB'($urandom_range(0, 15));
      default: return CMAX - CB'($urandom_range(0, 15));
    endcase
  endfunction

  // Offer one rectangle and hold it until the block takes it. Keep valid
  // high into the next word when no gap is drawn.
  task automatic send_rect(input logic [CB-1:0] lx, input logic [CB-1:0] ly,
                           input logic [CB-1:0] hx, input logic [CB-1:0] hy);
    int gap;
    gap = sender_idles ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 4 * CB){1'b0}}, hy, hx, ly, lx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every key has come out.
  task automatic drain_keys();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (keys_outstanding != 0) @(posedge clk);
  endtask

  // Write top_bit with the pipeline empty, after its latency has passed.
  task automatic write_top_bit(input logic [rchk_pkg::TOP_W-1:0] value);
    drain_keys();
    repeat (6) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random_rect();
    send_rect(draw_coord(), draw_coord(), draw_coord(), draw_coord());
  endtask

  initial begin
    logic [rchk_pkg::TOP_W-1:0] phase_tops[10];
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset top_bit.
    send_rect('0, '0, '0, '0);
    send_rect(CMAX, CMAX, CMAX, CMAX);          // corners above one
    send_rect(ONE, ONE, ONE, ONE);
    send_rect('0, '0, ONE, ONE);
    send_rect(ONE, ONE, '0, '0);                // low above high
    send_rect(CMAX, '0, CMAX - CB'(1), '0);     // low above high, odd sum
    send_rect('0, '0, CMAX, CMAX);
    send_rect(CMAX, '0, CMAX, '0);              // x at max, y zero
    send_rect('0, CMAX, '0, CMAX);              // x zero, y at max
    send_rect(21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA);
    send_rect(21'h0AAAAA, 21'h155555, 21'h0AAAAA, 21'h155555);
    send_rect(21'h000001, 21'h000000, 21'h000001, 21'h000000);
    send_rect(21'h100000, 21'h080000, 21'h100000, 21'h080000);
    send_rect(21'h0FFFFF, 21'h0FFFFF, 21'h100001, 21'h100001);

    // Small top_bit: center bits above it are ignored.
    write_top_bit(5'd0);
    send_rect(CMAX, CMAX, CMAX, CMAX);
    send_rect(21'h000001, '0, 21'h000001, '0);
    send_rect('0, 21'h000001, '0, 21'h000001);
    send_rect(21'h000001, 21'h000001, 21'h000001, 21'h000001);
    write_top_bit(5'd4);
    send_rect(CMAX, '0, CMAX, '0);
    send_rect(21'h0000FF, 21'h00000F, 21'h0000FF, 21'h00000F);
    send_rect(21'h15555A, 21'h0AAAA5, 21'h15555A, 21'h0AAAA5);

    // Random phases across several settings, the extremes among them.
    phase_tops = '{5'd31, 5'd0, 5'd20, 5'd31, 5'd1, 5'd21, 5'd0, 5'd5, 5'd31, 5'd0};
    phase_tops[6] = TW'($urandom_range(0, 31));
    phase_tops[9] = TW'($urandom_range(0, 31));
    for (int p = 0; p < 10; p++) begin
      write_top_bit(phase_tops[p]);
      sender_idles   = (p % 3) != 2;
      receiver_idles = (p % 4) != 1;
      if (p == 3) begin
        // Back up the pipeline: receiver holds off while words keep coming.
        sender_idles = 1'b0;
        rx_hold_req  = 1'b1;
      end
      for (int i = 0; i < 100; i++) begin
        if (p == 5 && i == 50)
          drain_keys();
        send_random_rect();
      end
    end

    drain_keys();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && keys_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
